// File: rtl/shd_pkg.sv
// shared constants and control structs of the sync hunt frame deframer
// no dependencies
`default_nettype none

package shd_pkg;

    localparam int FRAME_BYTES = 41;
    localparam int LINE_CHARS  = 16;
    localparam int HALF_CHARS  = LINE_CHARS / 2;
    localparam int ROW1_POS    = 5;
    localparam int LINE1_POS   = 6;
    localparam int ROW2_POS    = 22;
    localparam int LINE2_POS   = 23;
    localparam int CHECK_POS   = FRAME_BYTES - 2;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);

    localparam logic [7:0]  SYNC_RESET = 8'd2;
    localparam logic [15:0] SUM_SEED   = 16'hFFFF;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic start;
        logic step;
    } scan_ctrl_t;

    typedef struct packed {
        logic        last;
        logic        found;
        pos_t        hit_pos;
        logic [15:0] sum;
    } scan_stat_t;

endpackage

`default_nettype wire

// File: rtl/shd_ifs.sv
// handshake channels of the deframer: received bytes in, decoded frames out
// no dependencies
`default_nettype none

interface shd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface shd_frame_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_bytes;
    logic [7:0]  row1_addr;
    logic [63:0] line1_high;
    logic [63:0] line1_low;
    logic [7:0]  row2_addr;
    logic [63:0] line2_high;
    logic [63:0] line2_low;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;

    modport source (output valid, output header_bytes, output row1_addr,
                    output line1_high, output line1_low, output row2_addr,
                    output line2_high, output line2_low, output good_frames,
                    output bad_frames, input ready);
    modport sink (input valid, input header_bytes, input row1_addr,
                  input line1_high, input line1_low, input row2_addr,
                  input line2_high, input line2_low, input good_frames,
                  input bad_frames, output ready);
endinterface

`default_nettype wire

// File: rtl/shd_cell.sv
// one byte cell of the frame chain, loads its input byte when enabled
// no dependencies
`default_nettype none

module shd_cell (
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] d,
    output logic [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = en ? d : byte_reg;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule

`default_nettype wire

// File: rtl/shd_scan.sv
// checksum and sync search over the byte leaving the head of the chain
// depends on shd_pkg
`default_nettype none

module shd_scan
    import shd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scan_ctrl_t ctrl,
    input  logic [7:0] head,
    input  logic [7:0] sync_byte,
    output scan_stat_t stat
);

    pos_t        pos_reg;
    pos_t        pos_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic        found_reg;
    logic        found_next;
    pos_t        hit_reg;
    pos_t        hit_next;

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        found_next = found_reg;
        hit_next   = hit_reg;
        if (ctrl.start)
        begin
            pos_next   = '0;
            sum_next   = SUM_SEED;
            found_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            pos_next = pos_reg + pos_t'(1);
            if (pos_reg < pos_t'(CHECK_POS))
                sum_next = sum_reg - {8'd0, head};
            if (pos_reg != '0 && !found_reg && head == sync_byte)
            begin
                found_next = 1'b1;
                hit_next   = pos_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        hit_reg <= hit_next;
    end

    assign stat.last    = (pos_reg == pos_t'(FRAME_BYTES - 1));
    assign stat.found   = found_reg;
    assign stat.hit_pos = hit_reg;
    assign stat.sum     = sum_reg;

endmodule

`default_nettype wire

// File: rtl/sync_hunt_frame_deframer.sv
// sync hunt deframer top level: cell chain, scan unit, control and output register
// depends on shd_pkg, shd_ifs, shd_cell, shd_scan
`default_nettype none

// Received bytes enter a chain of 41 byte cells from the tail, so a partial frame sits
// right-aligned and dropping leading bytes only lowers the fill count. A byte that does not
// complete a frame is taken without leaving the idle state. The byte that completes a frame
// is followed by a scan, in which the chain rotates once past the scan unit that forms the
// checksum and looks for the next sync byte, and then by evaluation, which is held only
// while a previous frame still waits in the output register. No input is taken
// during the scan and evaluation. An accepted frame is shown with the good frame count
// including itself; a mismatch bumps the bad frame count and resyncs on the next sync byte.

module sync_hunt_frame_deframer
    import shd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    shd_byte_if.sink          rx,
    shd_frame_if.source       frame
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    pos_t        fill_reg;
    pos_t        fill_next;
    logic [7:0]  sync_reg;
    logic [7:0]  sync_next;
    logic [31:0] good_reg;
    logic [31:0] good_next;
    logic [31:0] bad_reg;
    logic [31:0] bad_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [31:0] hdr_reg;
    logic [7:0]  row1_reg;
    logic [63:0] l1h_reg;
    logic [63:0] l1l_reg;
    logic [7:0]  row2_reg;
    logic [63:0] l2h_reg;
    logic [63:0] l2l_reg;
    logic [31:0] good_out_reg;
    logic [31:0] bad_out_reg;

    logic [7:0]  cell_q [FRAME_BYTES];
    logic [7:0]  tail_d;
    logic        chain_en;
    logic        rx_fire;
    logic        append;
    logic        rotate;
    logic        load_out;
    logic        sum_match;
    scan_ctrl_t  scan_ctrl;
    scan_stat_t  scan_stat;

    function automatic logic [63:0] pack8(input int pos, input logic [7:0] c [FRAME_BYTES]);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < HALF_CHARS; k++)
            v = {v[55:0], c[pos + k]};
        return v;
    endfunction

    assign rx.ready  = (state_reg == ST_IDLE);
    assign rx_fire   = rx.valid && rx.ready;
    assign append    = rx_fire && (fill_reg != '0 || rx.byte_in == sync_reg);
    assign rotate    = (state_reg == ST_SCAN);
    assign chain_en  = append || rotate;
    assign tail_d    = rotate ? cell_q[0] : rx.byte_in;
    assign sum_match = (scan_stat.sum == {cell_q[CHECK_POS], cell_q[CHECK_POS + 1]});
    assign load_out  = (state_reg == ST_EVAL) && sum_match && (!out_valid_reg || frame.ready);

    assign scan_ctrl.start = append && (fill_reg == pos_t'(FRAME_BYTES - 1));
    assign scan_ctrl.step  = rotate;

    genvar gi;
    generate
        for (gi = 0; gi < FRAME_BYTES; gi++)
        begin : g_cell
            if (gi == FRAME_BYTES - 1)
            begin : g_tail
                shd_cell u_cell (.clk(clk), .en(chain_en), .d(tail_d), .q(cell_q[gi]));
            end
            else
            begin : g_body
                shd_cell u_cell (.clk(clk), .en(chain_en), .d(cell_q[gi + 1]),
                                 .q(cell_q[gi]));
            end
        end
    endgenerate

    shd_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .head      (cell_q[0]),
        .sync_byte (sync_reg),
        .stat      (scan_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        sync_next      = cfg_we ? cfg_wdata : sync_reg;
        good_next      = good_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !frame.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (append)
                begin
                    fill_next = fill_reg + pos_t'(1);
                    if (scan_ctrl.start)
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_stat.last)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!sum_match)
                begin
                    bad_next   = bad_reg + 32'd1;
                    fill_next  = scan_stat.found ?
                                 pos_t'(FRAME_BYTES) - scan_stat.hit_pos : '0;
                    state_next = ST_IDLE;
                end
                else if (load_out)
                begin
                    good_next      = good_reg + 32'd1;
                    fill_next      = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            sync_reg      <= SYNC_RESET;
            good_reg      <= '0;
            bad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            sync_reg      <= sync_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            hdr_reg      <= {cell_q[1], cell_q[2], cell_q[3], cell_q[4]};
            row1_reg     <= cell_q[ROW1_POS];
            l1h_reg      <= pack8(LINE1_POS, cell_q);
            l1l_reg      <= pack8(LINE1_POS + HALF_CHARS, cell_q);
            row2_reg     <= cell_q[ROW2_POS];
            l2h_reg      <= pack8(LINE2_POS, cell_q);
            l2l_reg      <= pack8(LINE2_POS + HALF_CHARS, cell_q);
            good_out_reg <= good_reg + 32'd1;
            bad_out_reg  <= bad_reg;
        end
    end

    assign frame.valid        = out_valid_reg;
    assign frame.header_bytes = hdr_reg;
    assign frame.row1_addr    = row1_reg;
    assign frame.line1_high   = l1h_reg;
    assign frame.line1_low    = l1l_reg;
    assign frame.row2_addr    = row2_reg;
    assign frame.line2_high   = l2h_reg;
    assign frame.line2_low    = l2l_reg;
    assign frame.good_frames  = good_out_reg;
    assign frame.bad_frames   = bad_out_reg;

endmodule

`default_nettype wire
